// ----- rtl/swdod_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// swdod_pkg
// Shared types, constants and the month table of the overload detector.
// ----------------------------------------------------------------------------
package swdod_pkg;

  localparam int unsigned WindowDaysDefault = 7;
  localparam int unsigned CountW            = 16;
  localparam int unsigned DayNumW           = 23;
  localparam int unsigned OutTotalW         = 19;
  localparam int unsigned OutTotalMax       = 524287;
  localparam int unsigned JdOffset          = 32045;
  localparam int unsigned YearBias          = 4800;
  localparam int unsigned DaysPerYear       = 365;
  // ceil(2^17 / 25): exact quotient for values below 43690
  localparam int unsigned Recip25           = 5243;
  localparam int unsigned Recip25Shift      = 17;

  typedef struct packed {
    logic [4:0]  day;
    logic [3:0]  month;
    logic [13:0] year;
    logic [15:0] shipments_on_day;
    logic        last_of_site;
  } in_item_t;

  typedef struct packed {
    logic        overloaded;
    logic [18:0] window_total;
    logic        site_done;
  } out_item_t;

  typedef struct packed {
    logic load;
    logic calc_a;
    logic calc_b;
    logic drop;
    logic insert;
  } swdod_cmd_t;

  typedef struct packed {
    logic evict_hit;
    logic window_full;
  } swdod_sts_t;

  // (153 * m + 2) / 5 with m = month shifted to start in March
  function automatic logic [8:0] month_term(input logic [3:0] month);
    logic [8:0] t;
    case (month)
      4'd0:    t = 9'd275;
      4'd1:    t = 9'd306;
      4'd2:    t = 9'd337;
      4'd3:    t = 9'd0;
      4'd4:    t = 9'd31;
      4'd5:    t = 9'd61;
      4'd6:    t = 9'd92;
      4'd7:    t = 9'd122;
      4'd8:    t = 9'd153;
      4'd9:    t = 9'd184;
      4'd10:   t = 9'd214;
      4'd11:   t = 9'd245;
      4'd12:   t = 9'd275;
      4'd13:   t = 9'd306;
      4'd14:   t = 9'd337;
      default: t = 9'd367;
    endcase
    return t;
  endfunction

endpackage
`default_nettype wire

// ----- rtl/sliding_window_date_overload_detect_top.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sliding_window_date_overload_detect_top
// Per-site windowed shipment total with sticky overload flag.
//
//   channel  dir  handshake              payload
//   in       in   in_valid_i/in_ready_o   in_item_i  (in_item_t)
//   out      out  out_valid_o/out_ready_i out_item_o (out_item_t)
//   cfg      in   cfg_valid_i/cfg_ready_o cfg_data_i (max_count)
//
// One transaction at a time, aging out 0..WINDOW_DAYS window entries:
// accept, two day number stages, one eviction per cycle through the window
// ring, then insert. The next input is taken while a result waits in the output
// register; insert holds while that register is still full.
// Reset clears the window, total, flag and max_count; config always ready.
// ----------------------------------------------------------------------------
module sliding_window_date_overload_detect_top
  import swdod_pkg::*;
#(
  parameter int unsigned WINDOW_DAYS = WindowDaysDefault
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  output logic             in_ready_o,
  input  wire in_item_t    in_item_i,
  output logic             out_valid_o,
  input  wire logic        out_ready_i,
  output out_item_t        out_item_o,
  input  wire logic        cfg_valid_i,
  output logic             cfg_ready_o,
  input  wire logic [18:0] cfg_data_i
);

  swdod_cmd_t cmd;
  swdod_sts_t sts;

  assign cfg_ready_o = 1'b1;

  swdod_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  swdod_dpath #(
    .WINDOW_DAYS (WINDOW_DAYS)
  ) u_dpath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .in_item_i   (in_item_i),
    .cfg_valid_i (cfg_valid_i),
    .cfg_data_i  (cfg_data_i),
    .out_item_o  (out_item_o)
  );

endmodule
`default_nettype wire

// ----- rtl/swdod_ctrl.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// swdod_ctrl
// Sequencer: day number stages, eviction loop, insert and output handshake.
// ----------------------------------------------------------------------------
module swdod_ctrl
  import swdod_pkg::*;
(
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       in_valid_i,
  output logic            in_ready_o,
  output logic            out_valid_o,
  input  wire logic       out_ready_i,
  input  wire swdod_sts_t sts_i,
  output swdod_cmd_t      cmd_o
);

  localparam logic [2:0] StIdle   = 3'd0;
  localparam logic [2:0] StCalcA  = 3'd1;
  localparam logic [2:0] StCalcB  = 3'd2;
  localparam logic [2:0] StEvict  = 3'd3;
  localparam logic [2:0] StInsert = 3'd4;

  logic [2:0] state_q, state_d;
  logic       out_valid_q, out_valid_d;
  logic       out_free;

  assign out_free   = !out_valid_q || out_ready_i;
  assign in_ready_o = (state_q == StIdle);
  assign out_valid_o = out_valid_q;

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    case (state_q)
      StIdle: begin
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = StCalcA;
        end
      end
      StCalcA: begin
        cmd_o.calc_a = 1'b1;
        state_d      = StCalcB;
      end
      StCalcB: begin
        cmd_o.calc_b = 1'b1;
        state_d      = StEvict;
      end
      StEvict: begin
        cmd_o.drop = sts_i.evict_hit || sts_i.window_full;
        if (!sts_i.evict_hit) begin
          state_d = StInsert;
        end
      end
      StInsert: begin
        if (out_free) begin
          cmd_o.insert = 1'b1;
          state_d      = StIdle;
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd_o.insert) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  a_one_in_flight: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("second transaction accepted while one is in flight");

  a_insert_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.insert |-> out_free)
    else $error("result written over an untaken result");

  a_load_then_calc: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.load |=> cmd_o.calc_a ##1 cmd_o.calc_b)
    else $error("day number stages out of order");

endmodule
`default_nettype wire

// ----- rtl/swdod_dpath.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// swdod_dpath
// Day number arithmetic, window ring, running total, flag and result register.
// ----------------------------------------------------------------------------
module swdod_dpath
  import swdod_pkg::*;
#(
  parameter int unsigned WINDOW_DAYS = WindowDaysDefault
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire swdod_cmd_t  cmd_i,
  output swdod_sts_t       sts_o,
  input  wire in_item_t    in_item_i,
  input  wire logic        cfg_valid_i,
  input  wire logic [18:0] cfg_data_i,
  output out_item_t        out_item_o
);

  localparam int unsigned IW = (WINDOW_DAYS > 1) ? $clog2(WINDOW_DAYS) : 1;
  localparam int unsigned FW = $clog2(WINDOW_DAYS + 1);
  localparam int unsigned SW = ((IW > FW) ? IW : FW) + 1;
  localparam int unsigned TW = $clog2(WINDOW_DAYS * 65535 + 1);

  // input stage
  logic [4:0]          day_q;
  logic [8:0]          mterm_q;
  logic [14:0]         y_q;
  logic [CountW-1:0]   cnt_in_q;
  logic                last_q;
  // product stage
  logic [23:0]         p365_q;
  logic [12:0]         y4_q;
  logic [8:0]          y100_q;
  logic [9:0]          base_q;
  logic [25:0]         y100_prod;
  // day number
  logic [DayNumW-1:0]  jd_q;
  logic [24:0]         jd_sum;
  // window
  logic [DayNumW-1:0]  dn_q  [WINDOW_DAYS];
  logic [CountW-1:0]   cnt_q [WINDOW_DAYS];
  logic [IW-1:0]       head_q;
  logic [FW-1:0]       fill_q;
  logic [TW-1:0]       total_q;
  logic                ovl_q;
  logic [18:0]         max_q;
  out_item_t           out_q;

  logic [DayNumW:0]    age;
  logic [SW-1:0]       slot_sum;
  logic [IW-1:0]       slot;
  logic [IW-1:0]       head_nxt;
  logic [TW-1:0]       total_new;
  logic                ovl_new;

  assign y100_prod = 26'(y_q[14:2]) * 26'(Recip25);

  assign jd_sum = 25'(p365_q) + 25'(y4_q) + 25'(y100_q[8:2]) + 25'(base_q)
                - 25'(y100_q) - 25'(JdOffset);

  assign age = {1'b0, jd_q} - {1'b0, dn_q[head_q]};

  assign sts_o.evict_hit   = (fill_q != '0) && !age[DayNumW]
                           && (age[DayNumW-1:0] >= DayNumW'(WINDOW_DAYS));
  assign sts_o.window_full = (fill_q == FW'(WINDOW_DAYS));

  assign head_nxt = (head_q == IW'(WINDOW_DAYS - 1)) ? '0 : head_q + 1'b1;

  always_comb begin
    slot_sum = SW'(head_q) + SW'(fill_q);
    if (slot_sum >= SW'(WINDOW_DAYS)) begin
      slot_sum = slot_sum - SW'(WINDOW_DAYS);
    end
    slot = slot_sum[IW-1:0];
  end

  assign total_new = total_q + TW'(cnt_in_q);
  assign ovl_new   = ovl_q || (32'(total_new) > 32'(max_q));

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      day_q    <= in_item_i.day;
      mterm_q  <= month_term(in_item_i.month);
      y_q      <= 15'(in_item_i.year) + 15'(YearBias)
                - ((in_item_i.month <= 4'd2) ? 15'd1 : 15'd0);
      cnt_in_q <= in_item_i.shipments_on_day;
      last_q   <= in_item_i.last_of_site;
    end
    if (cmd_i.calc_a) begin
      p365_q <= 24'(y_q) * 24'(DaysPerYear);
      y4_q   <= y_q[14:2];
      y100_q <= y100_prod[25:Recip25Shift];
      base_q <= 10'(day_q) + 10'(mterm_q);
    end
    if (cmd_i.calc_b) begin
      jd_q <= jd_sum[DayNumW-1:0];
    end
    if (cmd_i.insert) begin
      dn_q[slot]              <= jd_q;
      cnt_q[slot]             <= cnt_in_q;
      out_q.overloaded        <= ovl_new;
      out_q.window_total      <= (32'(total_new) > 32'(OutTotalMax)) ?
                                 OutTotalW'(OutTotalMax) : OutTotalW'(total_new);
      out_q.site_done         <= last_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q  <= '0;
      fill_q  <= '0;
      total_q <= '0;
      ovl_q   <= 1'b0;
      max_q   <= '0;
    end else begin
      if (cfg_valid_i) begin
        max_q <= cfg_data_i;
      end
      if (cmd_i.drop) begin
        total_q <= total_q - TW'(cnt_q[head_q]);
        head_q  <= head_nxt;
        fill_q  <= fill_q - 1'b1;
      end else if (cmd_i.insert) begin
        if (last_q) begin
          head_q  <= '0;
          fill_q  <= '0;
          total_q <= '0;
          ovl_q   <= 1'b0;
        end else begin
          fill_q  <= fill_q + 1'b1;
          total_q <= total_new;
          ovl_q   <= ovl_new;
        end
      end
    end
  end

  assign out_item_o = out_q;

  a_fill_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fill_q <= FW'(WINDOW_DAYS))
    else $error("window fill beyond capacity");

  a_empty_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fill_q == '0 |-> total_q == '0)
    else $error("empty window with nonzero total");

  a_drop_nonempty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.drop |-> fill_q != '0)
    else $error("eviction from an empty window");

endmodule
`default_nettype wire
